/* rtl/etot_pkg.sv */
// shared types and constants for the euler totient block
package etot_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // request to the shared divider
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    // status and answer from the shared divider
    typedef struct packed {
        logic  done;
        word_t quotient;
        word_t remainder;
    } div_rsp_t;

endpackage

/* rtl/etot_div.sv */
// restoring divider, one quotient bit per cycle
module etot_div
    import etot_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic  busy_reg, busy_next;
    logic  done_reg, done_next;
    cnt_t  count_reg, count_next;
    word_t acc_reg, acc_next;
    word_t quo_reg, quo_next;
    word_t dsr_reg, dsr_next;

    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;

    always_comb
    begin
        trial = {acc_reg, quo_reg[WIDTH-1]};
        diff  = trial - {1'b0, dsr_reg};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;

        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = cnt_t'(WIDTH - 1);
            acc_next   = '0;
            quo_next   = req.dividend;
            dsr_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            if (!diff[WIDTH])
            begin
                acc_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                acc_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = acc_reg;

endmodule

/* rtl/euler_totient.sv */
// euler totient by trial division over one shared iterative divider
//
// usage:
//   n_value arrives on a valid/ready request channel; one phi_value leaves
//   on a valid/ready channel for every request taken.
//   the block takes one request at a time: in_ready is high only while the
//   sequencer is idle, so a request waits until the previous one is worked out.
//   every step is a 32-bit division on the shared divider, one division per
//   trial divisor up to sqrt(n) plus a few per prime factor found; a prime
//   near 2^32 needs about 65536 divisions.
//   the result sits in an output register; the next request is taken while
//   it waits. a result that finds the output register still full waits in
//   the sequencer until the receiver takes the old one.
//   reset (rst_n low) empties the output register and returns the
//   sequencer to idle; no clearing pass is needed.
module euler_totient
    import etot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] n_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] phi_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIAL,
        S_RES,
        S_STRIP,
        S_LAST,
        S_FINISH
    } state_t;

    state_t   state_reg, state_next;
    word_t    rem_reg, rem_next;
    word_t    res_reg, res_next;
    word_t    d_reg, d_next;
    logic     out_valid_reg, out_valid_next;
    word_t    phi_reg, phi_next;
    div_req_t req_reg, req_next;
    div_rsp_t rsp;

    etot_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg;
        phi_next       = phi_reg;
        req_next       = req_reg;
        req_next.start = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next       = word_t'(n_value);
                    res_next       = word_t'(n_value);
                    d_next         = word_t'(2);
                    req_next.start    = 1'b1;
                    req_next.dividend = word_t'(n_value);
                    req_next.divisor  = word_t'(2);
                    state_next     = S_TRIAL;
                end
            end
            S_TRIAL:
            begin
                if (rsp.done)
                begin
                    if (d_reg > rsp.quotient)
                    begin
                        // d squared beyond remainder: what is left is prime or one
                        if (rem_reg > word_t'(1))
                        begin
                            req_next.start    = 1'b1;
                            req_next.dividend = res_reg;
                            req_next.divisor  = rem_reg;
                            state_next        = S_LAST;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    else if (rsp.remainder == '0)
                    begin
                        rem_next          = rsp.quotient;
                        req_next.start    = 1'b1;
                        req_next.dividend = res_reg;
                        req_next.divisor  = d_reg;
                        state_next        = S_RES;
                    end
                    else
                    begin
                        d_next            = d_reg + 1'b1;
                        req_next.start    = 1'b1;
                        req_next.dividend = rem_reg;
                        req_next.divisor  = d_reg + 1'b1;
                    end
                end
            end
            S_RES:
            begin
                if (rsp.done)
                begin
                    res_next          = res_reg - rsp.quotient;
                    req_next.start    = 1'b1;
                    req_next.dividend = rem_reg;
                    req_next.divisor  = d_reg;
                    state_next        = S_STRIP;
                end
            end
            S_STRIP:
            begin
                // divide the factor out completely
                if (rsp.done)
                begin
                    req_next.start    = 1'b1;
                    req_next.dividend = rem_reg;
                    if (rsp.remainder == '0)
                    begin
                        rem_next          = rsp.quotient;
                        req_next.dividend = rsp.quotient;
                        req_next.divisor  = d_reg;
                    end
                    else
                    begin
                        d_next           = d_reg + 1'b1;
                        req_next.divisor = d_reg + 1'b1;
                        state_next       = S_TRIAL;
                    end
                end
            end
            S_LAST:
            begin
                if (rsp.done)
                begin
                    res_next   = res_reg - rsp.quotient;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    phi_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            req_reg       <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg          <= rem_next;
        res_reg          <= res_next;
        d_reg            <= d_next;
        phi_reg          <= phi_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign phi_value = 32'(phi_reg);

endmodule
